FILE: design/barycentric_triangle_pixel_shader_defines.svh
// Assertion helpers for the shader.
`ifndef BARYCENTRIC_TRIANGLE_PIXEL_SHADER_DEFINES_SVH
`define BARYCENTRIC_TRIANGLE_PIXEL_SHADER_DEFINES_SVH

// Property that holds on every clock edge outside reset.
`define BTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property checked at every clock edge, reset included.
`define BTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/bts_pkg.sv
package bts_pkg;

    localparam int COORD_BITS   = 10;
    localparam int NUM_REGS     = 6;
    localparam int ADDR_BITS    = 5;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int NUM_BITS     = PROD_BITS + 2;
    localparam int COLOR_BITS   = 8;
    localparam int REM_BITS     = NUM_BITS + COLOR_BITS;
    localparam int DIV_STEPS    = COLOR_BITS;
    localparam int PAY_BITS     = 2 * COORD_BITS;
    localparam int S_TDATA_BITS = ((PAY_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = PAY_BITS + 1 + 3 * COLOR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [ADDR_BITS-1:0] ADDR_AX = ADDR_BITS'(0);
    localparam logic [ADDR_BITS-1:0] ADDR_AY = ADDR_BITS'(4);
    localparam logic [ADDR_BITS-1:0] ADDR_BX = ADDR_BITS'(8);
    localparam logic [ADDR_BITS-1:0] ADDR_BY = ADDR_BITS'(12);
    localparam logic [ADDR_BITS-1:0] ADDR_CX = ADDR_BITS'(16);
    localparam logic [ADDR_BITS-1:0] ADDR_CY = ADDR_BITS'(20);

    typedef struct packed {
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
    } t_tri;

    // one element of the divider pipe: remainders and quotient bits per color
    typedef struct packed {
        logic                    vld;
        logic                    in_tri;
        logic [PAY_BITS-1:0]     xy;
        logic [REM_BITS-1:0]     d;
        logic [REM_BITS-1:0]     rem_r;
        logic [REM_BITS-1:0]     rem_g;
        logic [REM_BITS-1:0]     rem_b;
        logic [COLOR_BITS-1:0]   q_r;
        logic [COLOR_BITS-1:0]   q_g;
        logic [COLOR_BITS-1:0]   q_b;
    } t_div;

endpackage

FILE: design/bts_cfg.sv
module bts_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bts_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output bts_pkg::t_tri                  o_tri
);
    import bts_pkg::*;

    t_tri r_tri;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_tri  = r_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri <= '0;
        end else if (wr) begin
            case (paddr)
                ADDR_AX: r_tri.ax <= pwdata[COORD_BITS-1:0];
                ADDR_AY: r_tri.ay <= pwdata[COORD_BITS-1:0];
                ADDR_BX: r_tri.bx <= pwdata[COORD_BITS-1:0];
                ADDR_BY: r_tri.by <= pwdata[COORD_BITS-1:0];
                ADDR_CX: r_tri.cx <= pwdata[COORD_BITS-1:0];
                ADDR_CY: r_tri.cy <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_AX: prdata = 32'(r_tri.ax);
            ADDR_AY: prdata = 32'(r_tri.ay);
            ADDR_BX: prdata = 32'(r_tri.bx);
            ADDR_BY: prdata = 32'(r_tri.by);
            ADDR_CX: prdata = 32'(r_tri.cx);
            ADDR_CY: prdata = 32'(r_tri.cy);
            default: prdata = '0;
        endcase
    end
endmodule

FILE: design/bts_edge.sv
// Stages 1-4: products, numerators, sign fold and inside test, color numerators.
module bts_edge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [bts_pkg::PAY_BITS-1:0]  i_xy,
    input  bts_pkg::t_tri                 i_tri,
    output bts_pkg::t_div                 o_div
);
    import bts_pkg::*;

    typedef logic signed [DIFF_BITS-1:0] t_diff;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [NUM_BITS-1:0]  t_num;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [PAY_BITS-1:0]  r_xy1, r_xy2, r_xy3, r_xy4;
    t_prod                r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    t_num                 r_d, r_nb, r_ng;
    t_num                 r_dab, r_nbf, r_ngf;
    logic                 r_in3, r_in4;
    logic [REM_BITS-1:0]  r_den, r_num_r, r_num_g, r_num_b;

    t_diff px, py, ax, ay, bx, by, cx, cy;
    t_num  d_abs, nb_f, ng_f, na_f;
    logic  neg, in_ok;
    logic [REM_BITS-1:0] dw, nbw, ngw;

    always_comb begin
        px = t_diff'({1'b0, i_xy[COORD_BITS-1:0]});
        py = t_diff'({1'b0, i_xy[PAY_BITS-1:COORD_BITS]});
        ax = t_diff'({1'b0, i_tri.ax});
        ay = t_diff'({1'b0, i_tri.ay});
        bx = t_diff'({1'b0, i_tri.bx});
        by = t_diff'({1'b0, i_tri.by});
        cx = t_diff'({1'b0, i_tri.cx});
        cy = t_diff'({1'b0, i_tri.cy});
    end

    always_comb begin
        neg   = r_d[NUM_BITS-1];
        d_abs = neg ? -r_d  : r_d;
        nb_f  = neg ? -r_nb : r_nb;
        ng_f  = neg ? -r_ng : r_ng;
        na_f  = d_abs - nb_f - ng_f;
        in_ok = (d_abs != '0)
             && (na_f > 0) && (na_f < d_abs)
             && (nb_f > 0) && (nb_f < d_abs)
             && (ng_f > 0) && (ng_f < d_abs);
    end

    always_comb begin
        dw  = REM_BITS'(r_dab);
        nbw = REM_BITS'(r_nbf);
        ngw = REM_BITS'(r_ngf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xy1 <= i_xy;
            r_p0  <= (bx - ax) * (cy - ay);
            r_p1  <= (cx - ax) * (by - ay);
            r_p2  <= (ax - cx) * (py - cy);
            r_p3  <= (px - cx) * (ay - cy);
            r_p4  <= (bx - ax) * (py - ay);
            r_p5  <= (px - ax) * (by - ay);
            r_xy2 <= r_xy1;
            r_d   <= t_num'(r_p0) - t_num'(r_p1);
            r_nb  <= t_num'(r_p2) - t_num'(r_p3);
            r_ng  <= t_num'(r_p4) - t_num'(r_p5);
            r_xy3 <= r_xy2;
            r_dab <= d_abs;
            r_nbf <= nb_f;
            r_ngf <= ng_f;
            r_in3 <= in_ok;
            r_xy4 <= r_xy3;
            r_in4 <= r_in3;
            // divisor 256*D; red 255*D - 127*Ng, green 223*Nb, blue 128*Ng
            r_den   <= dw << COLOR_BITS;
            r_num_r <= (dw << COLOR_BITS) - dw - (ngw << (COLOR_BITS - 1)) + ngw;
            r_num_g <= (nbw << COLOR_BITS) - (nbw << 5) - nbw;
            r_num_b <= ngw << (COLOR_BITS - 1);
        end
    end

    always_comb begin
        o_div        = '0;
        o_div.vld    = r_v4;
        o_div.in_tri = r_in4;
        o_div.xy     = r_xy4;
        o_div.d      = r_den;
        o_div.rem_r  = r_num_r;
        o_div.rem_g  = r_num_g;
        o_div.rem_b  = r_num_b;
    end
endmodule

FILE: design/bts_div.sv
// Restoring divider, one quotient bit per stage, three lanes share the divisor.
// The divisor is 256*D and each lane numerator n is below it, so eight
// shift-compare-subtract steps leave floor(n/D) in the quotient bits.
module bts_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  bts_pkg::t_div i_div,
    output bts_pkg::t_div o_div
);
    import bts_pkg::*;

    t_div r_st [DIV_STEPS];
    t_div n_st [DIV_STEPS];

    function automatic logic [REM_BITS:0] step(input logic [REM_BITS-1:0] rem,
                                               input logic [REM_BITS-1:0] d);
        logic [REM_BITS-1:0] tw;
        tw = rem << 1;
        if (tw >= d) step = {1'b1, tw - d};
        else         step = {1'b0, tw};
    endfunction

    function automatic t_div advance(input t_div src);
        t_div              dst;
        logic [REM_BITS:0] sr, sg, sb;
        dst       = src;
        sr        = step(src.rem_r, src.d);
        sg        = step(src.rem_g, src.d);
        sb        = step(src.rem_b, src.d);
        dst.rem_r = sr[REM_BITS-1:0];
        dst.rem_g = sg[REM_BITS-1:0];
        dst.rem_b = sb[REM_BITS-1:0];
        dst.q_r   = {src.q_r[COLOR_BITS-2:0], sr[REM_BITS]};
        dst.q_g   = {src.q_g[COLOR_BITS-2:0], sg[REM_BITS]};
        dst.q_b   = {src.q_b[COLOR_BITS-2:0], sb[REM_BITS]};
        return dst;
    endfunction

    always_comb begin
        n_st[0] = advance(i_div);
        for (int s = 1; s < DIV_STEPS; s++) begin
            n_st[s] = advance(r_st[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (!i_rst_n) begin
                r_st[s].vld <= 1'b0;
            end else if (i_en) begin
                r_st[s].vld <= n_st[s].vld;
            end
            if (i_en) begin
                r_st[s].in_tri <= n_st[s].in_tri;
                r_st[s].xy     <= n_st[s].xy;
                r_st[s].d      <= n_st[s].d;
                r_st[s].rem_r  <= n_st[s].rem_r;
                r_st[s].rem_g  <= n_st[s].rem_g;
                r_st[s].rem_b  <= n_st[s].rem_b;
                r_st[s].q_r    <= n_st[s].q_r;
                r_st[s].q_g    <= n_st[s].q_g;
                r_st[s].q_b    <= n_st[s].q_b;
            end
        end
    end

    assign o_div = r_st[DIV_STEPS-1];
endmodule

FILE: design/bts_scale.sv
// Output stage: colors of pixels outside the triangle are forced to zero.
module bts_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  bts_pkg::t_div i_div,
    output logic          o_vld,
    output logic [bts_pkg::PAY_BITS-1:0] o_xy,
    output logic          o_in_tri,
    output logic [bts_pkg::COLOR_BITS-1:0] o_red,
    output logic [bts_pkg::COLOR_BITS-1:0] o_green,
    output logic [bts_pkg::COLOR_BITS-1:0] o_blue
);
    import bts_pkg::*;

    logic                  r_vld;
    logic [PAY_BITS-1:0]   r_xy;
    logic                  r_in;
    logic [COLOR_BITS-1:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_div.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xy    <= i_div.xy;
            r_in    <= i_div.in_tri;
            r_red   <= i_div.in_tri ? i_div.q_r : '0;
            r_green <= i_div.in_tri ? i_div.q_g : '0;
            r_blue  <= i_div.in_tri ? i_div.q_b : '0;
        end
    end

    assign o_vld    = r_vld;
    assign o_xy     = r_xy;
    assign o_in_tri = r_in;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
endmodule

FILE: design/barycentric_triangle_pixel_shader.sv
// channel | dir | fields (low bit first)
// s_axis  | in  | pixel_x[9:0], pixel_y[19:10]
// m_axis  | out | out_x, out_y, inside_res, red, green, blue (tdata 48 bits)
// apb     | in  | six vertex registers at 0x00..0x14
// One word per cycle while the output is empty or taken; stages: edge math, divider, output.
// Synchronous active-low reset clears valid bits and vertex registers.
// The whole pipe advances when the output stage is empty or taken.
module barycentric_triangle_pixel_shader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [bts_pkg::S_TDATA_BITS-1:0] s_axis_tdata,   // pixel_x, pixel_y, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_x, out_y, inside_res, red, green, blue, pad
    output logic [bts_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [bts_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bts_pkg::*;
    `include "barycentric_triangle_pixel_shader_defines.svh"

    t_tri tri_v;
    t_div e2d, d2s;
    logic en, vld;
    logic [PAY_BITS-1:0] xy;
    logic in_tri;
    logic [COLOR_BITS-1:0] red, green, blue;
    logic no_color;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    bts_cfg u_cfg (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .pready, .o_tri(tri_v));

    bts_edge u_edge (.i_clk, .i_rst_n, .i_en(en), .i_vld(s_axis_tvalid),
                     .i_xy(s_axis_tdata[PAY_BITS-1:0]), .i_tri(tri_v), .o_div(e2d));

    bts_div u_div (.i_clk, .i_rst_n, .i_en(en), .i_div(e2d), .o_div(d2s));

    bts_scale u_scale (.i_clk, .i_rst_n, .i_en(en), .i_div(d2s), .o_vld(vld), .o_xy(xy),
                       .o_in_tri(in_tri), .o_red(red), .o_green(green), .o_blue(blue));

    assign m_axis_tvalid = vld;
    assign m_axis_tdata  = M_TDATA_BITS'({blue, green, red, in_tri, xy});
    assign no_color      = (red | green | blue) == '0;

    `BTS_ASSERT(a_out_zero, (m_axis_tvalid && !in_tri) |-> no_color, "colored outside pixel")
    `BTS_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
    `BTS_ASSERT_ALWAYS(a_pready, pready, "pready low")
endmodule

FILE: tb/tb_barycentric_triangle_pixel_shader.sv
`timescale 1ns / 100ps

module tb_barycentric_triangle_pixel_shader;
    import bts_pkg::*;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic       in_tri;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_res;

    class shade_scoreboard;
        logic [9:0]  vert[NUM_REGS] = '{default: '0};
        t_pixel_res  pending[$];
        int          errors;

        function t_pixel_res shade(logic [9:0] px, logic [9:0] py);
            t_pixel_res r;
            longint xa, ya, xb, yb, xc, yc, x, y, d, nb, ng, na;
            xa = vert[0]; ya = vert[1]; xb = vert[2];
            yb = vert[3]; xc = vert[4]; yc = vert[5];
            x = px; y = py;
            r = '0;
            r.x = px;
            r.y = py;
            d  = (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
            nb = (xa - xc) * (y - yc) - (x - xc) * (ya - yc);
            ng = (xb - xa) * (y - ya) - (x - xa) * (yb - ya);
            if (d != 0) begin
                if (d < 0) begin
                    d = -d; nb = -nb; ng = -ng;
                end
                na = d - nb - ng;
                if (na > 0 && na < d && nb > 0 && nb < d && ng > 0 && ng < d) begin
                    r.in_tri = 1'b1;
                    r.red    = 8'((255 * d - 127 * ng) / d);
                    r.green  = 8'((223 * nb) / d);
                    r.blue   = 8'((128 * ng) / d);
                end
            end
            return r;
        endfunction

        function void note_pixel(logic [9:0] px, logic [9:0] py);
            pending.push_back(shade(px, py));
        endfunction

        function void check_result(t_pixel_res got);
            t_pixel_res e;
            if (pending.size() == 0) begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x != e.x) begin
                $error("out_x exp %0d got %0d", e.x, got.x); errors++;
            end
            if (got.y != e.y) begin
                $error("out_y exp %0d got %0d", e.y, got.y); errors++;
            end
            if (got.in_tri != e.in_tri) begin
                $error("inside_res exp %0d got %0d", e.in_tri, got.in_tri); errors++;
            end
            if (got.red != e.red) begin
                $error("red exp %0d got %0d", e.red, got.red); errors++;
            end
            if (got.green != e.green) begin
                $error("green exp %0d got %0d", e.green, got.green); errors++;
            end
            if (got.blue != e.blue) begin
                $error("blue exp %0d got %0d", e.blue, got.blue); errors++;
            end
        endfunction
    endclass

    localparam logic [ADDR_BITS-1:0] VERT_ADDR[NUM_REGS] =
        '{ADDR_AX, ADDR_AY, ADDR_BX, ADDR_BY, ADDR_CX, ADDR_CY};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    shade_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycles = 0;

    barycentric_triangle_pixel_shader i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("** barycentric_triangle_pixel_shader: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_pixel_res got;
            got.x      = m_axis_tdata[9:0];
            got.y      = m_axis_tdata[19:10];
            got.in_tri = m_axis_tdata[20];
            got.red    = m_axis_tdata[28:21];
            got.green  = m_axis_tdata[36:29];
            got.blue   = m_axis_tdata[44:37];
            sb.check_result(got);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_vertex(int idx, logic [9:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= VERT_ADDR[idx]; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.vert[idx] = v;
    endtask

    task automatic set_triangle(logic [9:0] ax, ay, bx, by, cx, cy);
        write_vertex(0, ax); write_vertex(1, ay); write_vertex(2, bx);
        write_vertex(3, by); write_vertex(4, cx); write_vertex(5, cy);
    endtask

    task automatic send_pixel(logic [9:0] px, logic [9:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(px, py);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_triangle();
        int lo, hi;
        if ($urandom_range(3) == 0) begin
            lo = 0; hi = 1023;
        end else begin
            lo = $urandom_range(1000); hi = lo + $urandom_range(1023 - lo);
        end
        set_triangle(10'($urandom_range(hi, lo)), 10'($urandom_range(hi, lo)),
                     10'($urandom_range(hi, lo)), 10'($urandom_range(hi, lo)),
                     10'($urandom_range(hi, lo)), 10'($urandom_range(hi, lo)));
    endtask

    task automatic random_pixels(int n);
        int xmin, xmax, ymin, ymax;
        xmin = int'(sb.vert[0]); xmax = int'(sb.vert[0]);
        ymin = int'(sb.vert[1]); ymax = int'(sb.vert[1]);
        for (int k = 1; k < 3; k++) begin
            if (sb.vert[2*k] < xmin) xmin = int'(sb.vert[2*k]);
            if (sb.vert[2*k] > xmax) xmax = int'(sb.vert[2*k]);
            if (sb.vert[2*k+1] < ymin) ymin = int'(sb.vert[2*k+1]);
            if (sb.vert[2*k+1] > ymax) ymax = int'(sb.vert[2*k+1]);
        end
        repeat (n) begin
            if ($urandom_range(9) < 8)
                send_pixel(10'($urandom_range(xmax, xmin)), 10'($urandom_range(ymax, ymin)));
            else
                send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
        end
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        phase_idle  = '{0, 82, 0, 23};
        phase_stall = '{0, 0, 82, 23};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset triangle is degenerate
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        drain();

        set_triangle(10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023);
        send_pixel(10'd1, 10'd1);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd5, 10'd0);
        send_pixel(10'd511, 10'd511);
        send_pixel(10'd512, 10'd511);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1, 10'd1021);
        send_pixel(10'd300, 10'd200);
        drain();

        // first triangle rotated half a turn, positive denominator
        set_triangle(10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd0);
        send_pixel(10'd1022, 10'd1022);
        send_pixel(10'd700, 10'd900);
        send_pixel(10'd2, 10'd1022);
        send_pixel(10'd341, 10'd682);
        drain();

        // collinear vertices
        set_triangle(10'd0, 10'd0, 10'd10, 10'd10, 10'd20, 10'd20);
        send_pixel(10'd5, 10'd5);
        send_pixel(10'd5, 10'd6);
        drain();

        set_triangle(10'd100, 10'd100, 10'd103, 10'd100, 10'd100, 10'd103);
        send_pixel(10'd101, 10'd101);
        send_pixel(10'd102, 10'd101);
        send_pixel(10'd682, 10'd341);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int t = 0; t < 9; t++) begin
                random_triangle();
                random_pixels(30);
                drain();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (sb.errors == 0)
            $display("** barycentric_triangle_pixel_shader: PASSED **");
        else
            $display("** barycentric_triangle_pixel_shader: FAILED **");
        $finish;
    end
endmodule

FILE: barycentric_triangle_pixel_shader.f
+incdir+design
design/bts_pkg.sv
design/bts_cfg.sv
design/bts_edge.sv
design/bts_div.sv
design/bts_scale.sv
design/barycentric_triangle_pixel_shader.sv
tb/tb_barycentric_triangle_pixel_shader.sv
